[rtl/core/spectrum_band_stop_magnitude_defines.svh]
// Assertion macros shared by the band-stop magnitude RTL.
// No dependencies; included by modules that carry assertions.
`ifndef SPECTRUM_BAND_STOP_MAGNITUDE_DEFINES_SVH
`define SPECTRUM_BAND_STOP_MAGNITUDE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SBSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sbsm_pkg.sv]
// Shared types and constants for the band-stop magnitude block.
// No dependencies.
package sbsm_pkg;

  localparam int MAX_POINTS = 4096;

  localparam int IDX_W   = 12;
  localparam int DATA_W  = 24;
  localparam int SUM_W   = 2 * DATA_W;   // re^2 + im^2 fits in 48 bits
  localparam int ROOT_W  = 35;
  localparam int REM_W   = ROOT_W + 1;
  localparam int LOG2_W  = 4;
  localparam int SHIFT_W = 3;
  localparam int CFG_W   = 12;
  localparam int CFG_AW  = 2;

  // Transform length limits (log2)
  localparam int LOG2_MIN  = 8;
  localparam int LOG2_CAP  = $clog2(MAX_POINTS + 1) - 1;
  localparam int LOG2_MAX  = (LOG2_CAP > 12) ? 12 : ((LOG2_CAP < 8) ? 8 : LOG2_CAP);

  // Root is taken of s * 4^PAD_PAIRS, then shifted down per bin
  localparam int PAD_PAIRS  = 10;
  localparam int SQRT_STEPS = SUM_W / 2 + PAD_PAIRS;

  typedef enum logic [CFG_AW-1:0] {
    REG_POINTS_LOG2 = 2'd0,
    REG_LOW_BIN     = 2'd1,
    REG_HIGH_BIN    = 2'd2
  } cfg_reg_t;

  // Per-item information that rides alongside the root
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic               masked;
    logic [SHIFT_W-1:0] shift;
  } side_t;

endpackage

[rtl/core/sbsm_isqrt_pipe.sv]
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on sbsm_pkg and spectrum_band_stop_magnitude_defines.svh.
`include "spectrum_band_stop_magnitude_defines.svh"

module sbsm_isqrt_pipe
  import sbsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side
);

  logic              vld_r  [SQRT_STEPS];
  logic [SUM_W-1:0]  sum_r  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_r [SQRT_STEPS];
  logic [REM_W-1:0]  rem_r  [SQRT_STEPS];
  side_t             side_r [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam int DIGIT = SQRT_STEPS - 1 - i;

    logic              vld_prev;
    logic [SUM_W-1:0]  sum_prev;
    logic [ROOT_W-1:0] root_prev;
    logic [REM_W-1:0]  rem_prev;
    side_t             side_prev;
    logic [1:0]        pair;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              take;
    logic [REM_W+1:0]  rem_diff;

    if (i == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign sum_prev  = in_sum;
      assign root_prev = '0;
      assign rem_prev  = '0;
      assign side_prev = in_side;
    end else begin : g_next
      assign vld_prev  = vld_r[i-1];
      assign sum_prev  = sum_r[i-1];
      assign root_prev = root_r[i-1];
      assign rem_prev  = rem_r[i-1];
      assign side_prev = side_r[i-1];
    end

    // Low PAD_PAIRS digit pairs are the zero padding
    if (DIGIT >= PAD_PAIRS) begin : g_data
      assign pair = sum_prev[2*(DIGIT-PAD_PAIRS)+1 : 2*(DIGIT-PAD_PAIRS)];
    end else begin : g_pad
      assign pair = 2'b00;
    end

    assign rem_sh   = {rem_prev, pair};
    assign trial    = {1'b0, root_prev, 2'b01};
    assign take     = (rem_sh >= trial);
    assign rem_diff = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sum_r[i]  <= sum_prev;
        side_r[i] <= side_prev;
        root_r[i] <= {root_prev[ROOT_W-2:0], take};
        rem_r[i]  <= take ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      end
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign out_root  = root_r[SQRT_STEPS-1];
  assign out_side  = side_r[SQRT_STEPS-1];

  // Remainder of a digit-by-digit root never exceeds twice the partial root
  `SBSM_ASSERT_NOW(a_rem_bound_mid, vld_r[SQRT_STEPS/2], rem_r[SQRT_STEPS/2] <= {root_r[SQRT_STEPS/2], 1'b0}, "isqrt remainder out of range mid-pipe")
  `SBSM_ASSERT_NOW(a_rem_bound_end, out_valid, rem_r[SQRT_STEPS-1] <= {out_root, 1'b0}, "isqrt remainder out of range at output")
  `SBSM_ASSERT_NEXT(a_hold_on_stall, !en, $stable(out_valid) && $stable(out_root), "isqrt pipe moved while stalled")

endmodule

[rtl/core/spectrum_band_stop_magnitude.sv]
// Band-stop mask and scaled magnitude for a stream of complex FFT bins.
// Depends on sbsm_pkg, sbsm_isqrt_pipe and spectrum_band_stop_magnitude_defines.svh.
`include "spectrum_band_stop_magnitude_defines.svh"

// Takes one FFT bin per transfer and returns one scaled magnitude per bin,
// one transfer per cycle sustained while results are taken; the path from input
// to output valid is 3 front stages, 34 square-root stages, 1 output register.
// The depth is set by the square root: one root bit per stage, 24 bits of
// data plus 10 bits of padding so that the 4/N and 2/N scales become a plain
// right shift at the end. The whole pipeline moves on one enable, held off
// only while the output register holds a result that is not taken. Bins in
// [low_bin, min(high_bin, N/2)] and their mirrors N-j are masked: magnitude
// 0 and was_masked set. When low_bin > high_bin no result is produced for
// any bin. Configuration writes are expected only while the pipe is empty.

module spectrum_band_stop_magnitude
  import sbsm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     cfg_we,
  input  logic [CFG_AW-1:0]        cfg_addr,
  input  logic [CFG_W-1:0]         cfg_wdata,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IDX_W-1:0]         in_bin_index,
  input  logic signed [DATA_W-1:0] in_real_part,
  input  logic signed [DATA_W-1:0] in_imag_part,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         out_index,
  output logic [ROOT_W-1:0]        out_magnitude,
  output logic                     out_was_masked
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [LOG2_W-1:0] points_log2_r;
  logic [IDX_W-1:0]  low_bin_r;
  logic [IDX_W-1:0]  high_bin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_log2_r <= LOG2_W'(12);
      low_bin_r     <= '1;
      high_bin_r    <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_POINTS_LOG2: points_log2_r <= cfg_wdata[LOG2_W-1:0];
        REG_LOW_BIN:     low_bin_r     <= cfg_wdata[IDX_W-1:0];
        REG_HIGH_BIN:    high_bin_r    <= cfg_wdata[IDX_W-1:0];
        default:         ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Global pipeline enable: everything advances unless the output is stuck
  // ---------------------------------------------------------------------
  logic pipe_en;
  logic out_valid_r;

  assign pipe_en  = !out_valid_r || out_ready;
  assign in_ready = pipe_en;

  // ---------------------------------------------------------------------
  // Front stage A: index wrap, band mask, absolute values
  // ---------------------------------------------------------------------
  logic [LOG2_W-1:0]  eff_log2;
  logic [IDX_W:0]     n_pts;
  logic [IDX_W:0]     half_pts;
  logic [IDX_W:0]     hi_lim;
  logic [IDX_W-1:0]   j_idx;
  logic [IDX_W:0]     k_dist;
  logic               band_hit;
  logic               band_ok;
  logic [SHIFT_W-1:0] shift_amt;
  logic [DATA_W-1:0]  abs_re;
  logic [DATA_W-1:0]  abs_im;

  always_comb begin
    priority if (points_log2_r < LOG2_W'(LOG2_MIN)) begin
      eff_log2 = LOG2_W'(LOG2_MIN);
    end else if (points_log2_r > LOG2_W'(LOG2_MAX)) begin
      eff_log2 = LOG2_W'(LOG2_MAX);
    end else begin
      eff_log2 = points_log2_r;
    end
  end

  assign n_pts    = (IDX_W+1)'(1) << eff_log2;
  assign half_pts = n_pts >> 1;
  assign hi_lim   = ({1'b0, high_bin_r} < half_pts) ? {1'b0, high_bin_r} : half_pts;
  assign j_idx    = in_bin_index & IDX_W'(n_pts - (IDX_W+1)'(1));
  // Distance to the nearer end: the mirror N-j for the upper half
  assign k_dist   = ({1'b0, j_idx} <= half_pts) ? {1'b0, j_idx} : (n_pts - {1'b0, j_idx});
  assign band_hit = (k_dist >= {1'b0, low_bin_r}) && (k_dist <= hi_lim);
  assign band_ok  = (low_bin_r <= high_bin_r);

  // 4/N scale is a right shift by log2-8 of the padded root; bin 0 one more
  assign shift_amt = SHIFT_W'(eff_log2 - LOG2_W'(LOG2_MIN))
                   + SHIFT_W'(j_idx == '0);

  assign abs_re = in_real_part[DATA_W-1] ? (~in_real_part + DATA_W'(1)) : in_real_part;
  assign abs_im = in_imag_part[DATA_W-1] ? (~in_imag_part + DATA_W'(1)) : in_imag_part;

  logic              a_valid_r;
  side_t             a_side_r;
  logic [DATA_W-1:0] a_abs_re_r;
  logic [DATA_W-1:0] a_abs_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (pipe_en) begin
      a_valid_r <= in_valid && band_ok;  // inverted band: item is dropped
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a_side_r.idx    <= j_idx;
      a_side_r.masked <= band_hit;
      a_side_r.shift  <= shift_amt;
      // masked bins feed zero into the root so the magnitude comes out 0
      a_abs_re_r      <= band_hit ? '0 : abs_re;
      a_abs_im_r      <= band_hit ? '0 : abs_im;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: squares
  // ---------------------------------------------------------------------
  logic             b_valid_r;
  side_t            b_side_r;
  logic [SUM_W-1:0] b_sq_re_r;
  logic [SUM_W-1:0] b_sq_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (pipe_en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      b_side_r  <= a_side_r;
      b_sq_re_r <= SUM_W'(a_abs_re_r) * SUM_W'(a_abs_re_r);
      b_sq_im_r <= SUM_W'(a_abs_im_r) * SUM_W'(a_abs_im_r);
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: sum of squares (at most 2^47)
  // ---------------------------------------------------------------------
  logic             c_valid_r;
  side_t            c_side_r;
  logic [SUM_W-1:0] c_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (pipe_en) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      c_side_r <= b_side_r;
      c_sum_r  <= b_sq_re_r + b_sq_im_r;
    end
  end

  // ---------------------------------------------------------------------
  // Square root of sum * 4^10, one bit per stage
  // ---------------------------------------------------------------------
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  sbsm_isqrt_pipe u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (c_valid_r),
    .in_sum    (c_sum_r),
    .in_side   (c_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---------------------------------------------------------------------
  // Output register: final scale shift (floor of floor is exact here)
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0]  out_index_r;
  logic [ROOT_W-1:0] out_magnitude_r;
  logic              out_was_masked_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_index_r      <= sq_side.idx;
      out_magnitude_r  <= sq_root >> sq_side.shift;
      out_was_masked_r <= sq_side.masked;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_index      = out_index_r;
  assign out_magnitude  = out_magnitude_r;
  assign out_was_masked = out_was_masked_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `SBSM_ASSERT_NOW(a_masked_zero, out_valid_r && out_was_masked_r, out_magnitude_r == '0, "masked bin produced nonzero magnitude")
  `SBSM_ASSERT_NEXT(a_inverted_drop, in_valid && in_ready && !band_ok, !a_valid_r, "item entered pipe with inverted band")
  `SBSM_ASSERT_NEXT(a_front_hold, !pipe_en, $stable(c_valid_r) && $stable(c_sum_r), "front stages moved while stalled")

endmodule

[sim/spectrum_band_stop_magnitude_test.sv]
// Self-checking bench for the band-stop magnitude block: directed and random bins,
// several register settings, random stalls on both channels.
// Depends on sbsm_pkg and spectrum_band_stop_magnitude only.
`timescale 1ns / 100ps

module spectrum_band_stop_magnitude_test;
  import sbsm_pkg::*;

  // Register index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [DATA_W-1:0] PART_MAX = 24'sh7FFFFF;
  localparam logic signed [DATA_W-1:0] PART_MIN = 24'sh800000;

  // Pipe is 38 deep; drain pause before any register write.
  localparam int DRAIN_CYCLES = 64;
  localparam int LONG_HOLD    = 200;
  localparam int ITEMS_PER_PHASE = 137;
  localparam int TIMEOUT_NS   = 2_000_000;

  typedef struct {
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } bin_item_t;

  typedef struct {
    logic [IDX_W-1:0]  index;
    logic [ROOT_W-1:0] magnitude;
    logic              masked;
  } bin_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                     cfg_we    = 1'b0;
  logic [CFG_AW-1:0]        cfg_addr  = '0;
  logic [CFG_W-1:0]         cfg_wdata = '0;

  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic [IDX_W-1:0]         in_bin_index = '0;
  logic signed [DATA_W-1:0] in_real_part = '0;
  logic signed [DATA_W-1:0] in_imag_part = '0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [IDX_W-1:0]         out_index;
  logic [ROOT_W-1:0]        out_magnitude;
  logic                     out_was_masked;

  // Shadow copy of the registers, updated as each write lands.
  logic [3:0]       shadow_log2 = 4'd12;
  logic [IDX_W-1:0] shadow_low  = 12'd4095;
  logic [IDX_W-1:0] shadow_high = 12'd4095;

  bin_item_t   pending_bins[$];
  bin_result_t expected_mags[$];

  int  mismatch_count = 0;
  int  send_idle_pct  = 0;
  int  recv_idle_pct  = 0;
  bit  sender_hold    = 1'b0;
  int  hold_requests  = 0;

  // Receiver-side bookkeeping for the long hold, owned by the receiver process.
  int  hold_seen = 0;
  int  hold_left = 0;

  spectrum_band_stop_magnitude uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_bin_index   (in_bin_index),
    .in_real_part   (in_real_part),
    .in_imag_part   (in_imag_part),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_index      (out_index),
    .out_magnitude  (out_magnitude),
    .out_was_masked (out_was_masked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Length register clamped to the supported 8..12 range.
  function automatic int points_log2_eff();
    int l;
    l = int'(shadow_log2);
    if (l < LOG2_MIN) l = LOG2_MIN;
    if (l > LOG2_MAX) l = LOG2_MAX;
    return l;
  endfunction

  // Expected magnitude transfer for one bin under the current registers.
  function automatic bin_result_t band_stop_result(bin_item_t item);
    bin_result_t      r;
    int unsigned      l, n, half, hi, j, fold;
    int               shift;
    logic signed [24:0] wide_re, wide_im;
    logic [24:0]      ar, ai;
    logic [47:0]      pwr;
    logic [79:0]      target, trial;
    logic [35:0]      root;
    l    = points_log2_eff();
    n    = 1 << l;
    half = n >> 1;
    hi   = (32'(shadow_high) < half) ? 32'(shadow_high) : half;
    j    = 32'(item.index) & (n - 1);
    // Upper half folds onto its conjugate partner; 0 and N/2 have none.
    fold = (j <= half) ? j : n - j;
    r.index     = j[IDX_W-1:0];
    r.masked    = (fold >= 32'(shadow_low)) && (fold <= hi);
    r.magnitude = '0;
    if (!r.masked) begin
      wide_re = 25'(item.re);
      wide_im = 25'(item.im);
      ar  = wide_re[24] ? -wide_re : wide_re;
      ai  = wide_im[24] ? -wide_im : wide_im;
      pwr = 48'(ar) * 48'(ar) + 48'(ai) * 48'(ai);
      // 4/N with 16 fraction bits is 2^(18-l); DC bin takes 2/N.
      shift  = (j == 0) ? 17 - int'(l) : 18 - int'(l);
      target = {32'd0, pwr} << (2 * shift);
      root   = '0;
      for (int b = 35; b >= 0; b--) begin
        trial = {44'd0, root} | (80'd1 << b);
        if (trial * trial <= target) root = trial[35:0];
      end
      r.magnitude = root[ROOT_W-1:0];
    end
    return r;
  endfunction

  // Sender: launches queued bins, predicts at each accepted transfer.
  always @(posedge clk) begin
    bin_item_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        item.index = in_bin_index;
        item.re    = in_real_part;
        item.im    = in_imag_part;
        // Inverted band: block swallows the bin
        if (shadow_low <= shadow_high) expected_mags.push_back(band_stop_result(item));
      end
      if (!in_valid || in_ready) begin
        if (!sender_hold && pending_bins.size() != 0 &&
            $urandom_range(99) >= send_idle_pct) begin
          item = pending_bins.pop_front();
          in_valid     <= 1'b1;
          in_bin_index <= item.index;
          in_real_part <= item.re;
          in_imag_part <= item.im;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus an occasional long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: each result transfer against the oldest expectation.
  always @(posedge clk) begin
    bin_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_mags.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: index %0d magnitude %0d masked %0d",
                   out_index, out_magnitude, out_was_masked);
      end else begin
        want = expected_mags.pop_front();
        if (out_index !== want.index || out_magnitude !== want.magnitude ||
            out_was_masked !== want.masked) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch (exp/got): index %0d/%0d magnitude %0d/%0d masked %0d/%0d",
                     want.index, out_index, want.magnitude, out_magnitude,
                     want.masked, out_was_masked);
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (addr)
      REG_POINTS_LOG2: shadow_log2 = value[3:0];
      REG_LOW_BIN:     shadow_low  = value;
      REG_HIGH_BIN:    shadow_high = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_W-1:0] log2_word,
                           input logic [CFG_W-1:0] low, input logic [CFG_W-1:0] high);
    write_reg(REG_POINTS_LOG2, log2_word);
    write_reg(REG_LOW_BIN, low);
    write_reg(REG_HIGH_BIN, high);
  endtask

  task automatic push_bin(input logic [IDX_W-1:0] idx,
                          input logic signed [DATA_W-1:0] re,
                          input logic signed [DATA_W-1:0] im);
    bin_item_t item;
    item.index = idx;
    item.re    = re;
    item.im    = im;
    pending_bins.push_back(item);
  endtask

  // Wait until nothing is queued, in flight or owed, then let the pipe settle.
  task automatic wait_drained();
    while (pending_bins.size() != 0 || in_valid || expected_mags.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] random_part();
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: case ($urandom_range(3))
           0: v = 32'(PART_MAX);
           1: v = 32'(PART_MIN);
           2: v = 0;
           default: v = -1;
         endcase
      2: v = $urandom_range(510) - 255;
      default: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v[DATA_W-1:0];
  endfunction

  // Random bins biased toward the band edges, DC, Nyquist and mirrors.
  task automatic push_random_bins(input int count);
    int unsigned n, sel;
    logic [31:0] idx;
    for (int i = 0; i < count; i++) begin
      n   = 1 << points_log2_eff();
      sel = $urandom_range(99);
      if (sel < 70)      idx = $urandom_range(n - 1);
      else if (sel < 75) idx = 0;
      else if (sel < 80) idx = n >> 1;
      else if (sel < 85) idx = 32'(shadow_low);
      else if (sel < 90) idx = n - 32'(shadow_low);
      else if (sel < 95) idx = 32'(shadow_high);
      else               idx = $urandom;   // past N: exercises wrap
      push_bin(idx[IDX_W-1:0], random_part(), random_part());
    end
  endtask

  initial begin
    int send_rate[3];
    int recv_rate[3];
    logic [CFG_W-1:0] log2_word, low, high;
    int lo_pick;
    send_rate = '{18, 58, 0};
    recv_rate = '{58, 18, 0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = send_rate[0];
    recv_idle_pct = recv_rate[0];

    // Reset registers: band starts past Nyquist, nothing masked.
    push_bin(12'd0,    PART_MAX, PART_MAX);
    push_bin(12'd0,    PART_MIN, PART_MIN);
    push_bin(12'd2048, PART_MIN, 24'sd0);
    push_bin(12'd4095, 24'sd0,   24'sd0);
    push_bin(12'd1,    -24'sd1,  24'sd1);
    wait_drained();

    // Length below range acts as 256 points; band 10..20 and its mirror.
    configure(12'd0, 12'd10, 12'd20);
    push_bin(12'd10,  PART_MAX, PART_MIN);
    push_bin(12'd20,  24'sd5,   24'sd7);
    push_bin(12'd21,  PART_MAX, PART_MAX);
    push_bin(12'd246, 24'sd100, -24'sd100);
    push_bin(12'd236, 24'sd3,   24'sd4);
    push_bin(12'd300, PART_MIN, PART_MAX);   // wraps to 44
    push_bin(12'd266, 24'sd9,   24'sd9);     // wraps to the masked 10
    push_bin(12'd128, PART_MIN, PART_MIN);
    wait_drained();

    // Length above range acts as 4096; high bin clipped to Nyquist.
    configure(12'd15, 12'd0, 12'd4095);
    push_bin(12'd0,    PART_MAX, PART_MAX);
    push_bin(12'd2048, PART_MAX, PART_MAX);
    push_bin(12'd4095, PART_MIN, PART_MIN);
    push_bin(12'd1,    24'sd1,   24'sd1);
    wait_drained();

    // Inverted band: no result transfers at all.
    configure(12'd12, 12'd5, 12'd4);
    write_reg(REG_UNUSED, 12'hFFF);
    push_bin(12'd5,  PART_MAX, PART_MAX);
    push_bin(12'd4,  24'sd1,   24'sd2);
    push_bin(12'd0,  PART_MIN, 24'sd0);
    wait_drained();

    // Band on Nyquist alone: N/2 has no mirror.
    configure(12'd8, 12'd128, 12'd128);
    push_bin(12'd128, PART_MAX, PART_MIN);
    push_bin(12'd129, PART_MAX, PART_MIN);
    wait_drained();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = send_rate[mode];
      recv_idle_pct = recv_rate[mode];
      for (int p = 0; p < 4; p++) begin
        if (mode == 0 && p == 1) begin
          // Long output hold while bins keep coming: pipe fills, input stalls.
          configure(12'd12, 12'd100, 12'd300);
          push_random_bins(ITEMS_PER_PHASE);
          hold_requests++;
        end else if (mode == 1 && p == 2) begin
          // Sender stops mid-stream until every owed result is out.
          configure(12'd9, 12'd0, 12'd0);
          push_random_bins(70);
          while (pending_bins.size() > 30) @(posedge clk);
          sender_hold = 1'b1;
          while (in_valid || expected_mags.size() != 0) @(posedge clk);
          sender_hold = 1'b0;
          push_random_bins(ITEMS_PER_PHASE - 70);
        end else begin
          if ($urandom_range(4) == 0) log2_word = CFG_W'($urandom_range(15));
          else                        log2_word = CFG_W'($urandom_range(8, 12));
          if ($urandom_range(3) == 0) log2_word[CFG_W-1:4] = (CFG_W-4)'($urandom);
          case ($urandom_range(9))
            0: begin
              low  = CFG_W'($urandom);
              high = CFG_W'($urandom);
            end
            1: begin
              lo_pick = $urandom_range(1, 4095);
              low  = CFG_W'(lo_pick);
              high = CFG_W'($urandom_range(lo_pick - 1));
            end
            2: begin
              lo_pick = $urandom_range(2048);
              low  = CFG_W'(lo_pick);
              high = CFG_W'(lo_pick + $urandom_range(1000));
            end
            default: begin
              lo_pick = $urandom_range(140);
              low  = CFG_W'(lo_pick);
              high = CFG_W'(lo_pick + $urandom_range(200));
            end
          endcase
          configure(log2_word, low, high);
          if ($urandom_range(3) == 0) write_reg(REG_UNUSED, CFG_W'($urandom));
          push_random_bins(ITEMS_PER_PHASE);
        end
        wait_drained();
      end
    end

    if (mismatch_count == 0 && expected_mags.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
